// ----- rtl/core/lp2p_pkg.sv -----
// Shared types, constants and datapath functions of the point-to-pixel projection.
`timescale 1ns / 1ps

package lp2p_pkg;

   localparam int unsigned QBITS = 17;   // integer quotient bits kept before rounding
   localparam int unsigned REM_W = 81;   // holds w << QBITS
   localparam int unsigned SUM_W = 67;   // exact signed row sum

   localparam logic [63:0] W_MIN_RAW        = 64'd429496729;  // 0.1 in Q32.32
   localparam logic [31:0] IMAGE_SIZE_RESET = 32'd24642208;   // 376 rows x 672 cols

   typedef enum logic [3:0] {
      CSR_ROW0_A      = 4'd0,
      CSR_ROW0_B      = 4'd1,
      CSR_ROW1_A      = 4'd2,
      CSR_ROW1_B      = 4'd3,
      CSR_ROW2_A      = 4'd4,
      CSR_ROW2_B      = 4'd5,
      CSR_IMAGE_SIZE  = 4'd6,
      CSR_GROUND_BAND = 4'd7
   } csr_index_type;

   typedef logic [5:0][63:0] matrix_type;

   typedef struct packed {
      logic        ground;
      logic        u_neg;
      logic [63:0] u_mag;
      logic        v_neg;
      logic [63:0] v_mag;
      logic        w_neg;
      logic [63:0] w_mag;
   } mac_item_type;

   typedef struct packed {
      logic             ground;
      logic             w_ok;
      logic             u_neg;
      logic             u_ovf;
      logic [REM_W-1:0] u_rem;
      logic [QBITS-1:0] u_q;
      logic             v_neg;
      logic             v_ovf;
      logic [REM_W-1:0] v_rem;
      logic [QBITS-1:0] v_q;
      logic [63:0]      w;
   } div_item_type;

   // Coefficient of row r, column c (signed Q16.16).
   function automatic logic signed [31:0] coef(matrix_type m, int r, int c);
      logic [63:0] reg_v;
      begin
         reg_v = m[(r * 2) + (c >> 1)];
         coef  = (c[0]) ? reg_v[63:32] : reg_v[31:0];
      end
   endfunction

   // One restoring-division step for both numerators, quotient bit k.
   function automatic div_item_type div_step(div_item_type it, int k);
      logic [REM_W-1:0] d;
      div_item_type     r;
      begin
         r = it;
         d = REM_W'(it.w) << k;
         if (it.u_rem >= d) begin
            r.u_rem  = it.u_rem - d;
            r.u_q[k] = 1'b1;
         end
         if (it.v_rem >= d) begin
            r.v_rem  = it.v_rem - d;
            r.v_q[k] = 1'b1;
         end
         div_step = r;
      end
   endfunction

endpackage

// ----- rtl/core/lp2p_mac.sv -----
// Matrix-vector stages: point capture, products, row sums, sign/magnitude split.
`timescale 1ns / 1ps

module lp2p_mac (
   input  logic                      clock,
   input  logic                      reset,
   input  lp2p_pkg::matrix_type      matrix,
   input  logic [63:0]               ground_band,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [31:0]        in_x,
   input  logic signed [31:0]        in_y,
   input  logic signed [31:0]        in_z,
   output logic                      out_valid,
   input  logic                      out_ready,
   output lp2p_pkg::mac_item_type    out_item
);

   logic [3:0] v_ff;
   logic [3:0] en;

   logic signed [31:0] pt_ff [3];
   logic               g1_ff;
   logic signed [63:0] p_ff [3][3];
   logic signed [31:0] t_ff [3];
   logic               g2_ff;
   logic signed [lp2p_pkg::SUM_W-1:0] s_ff [3];
   logic               g3_ff;
   lp2p_pkg::mac_item_type item_ff;
   lp2p_pkg::mac_item_type item_in;

   logic ground_in;
   logic signed [lp2p_pkg::SUM_W-1:0] mag_u, mag_v, mag_w;

   assign en[3]    = !v_ff[3] || out_ready;
   assign en[2]    = !v_ff[2] || en[3];
   assign en[1]    = !v_ff[1] || en[2];
   assign en[0]    = !v_ff[0] || en[1];
   assign in_ready = en[0];

   assign ground_in = (in_z > $signed(ground_band[31:0])) &&
                      (in_z < $signed(ground_band[63:32]));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
         if (en[2]) v_ff[2] <= v_ff[1];
         if (en[3]) v_ff[3] <= v_ff[2];
      end
   end

   // stage 1: capture point
   always_ff @(posedge clock) begin
      if (en[0]) begin
         pt_ff[0] <= in_x;
         pt_ff[1] <= in_y;
         pt_ff[2] <= in_z;
         g1_ff    <= ground_in;
      end
   end

   // stage 2: nine 32x32 signed products
   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               p_ff[r][c] <= lp2p_pkg::coef(matrix, r, c) * pt_ff[c];
            end
            t_ff[r] <= lp2p_pkg::coef(matrix, r, 3);
         end
         g2_ff <= g1_ff;
      end
   end

   // stage 3: exact row sums, translation scaled by one in Q16.16
   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int r = 0; r < 3; r++) begin
            s_ff[r] <= lp2p_pkg::SUM_W'(p_ff[r][0]) + lp2p_pkg::SUM_W'(p_ff[r][1])
                     + lp2p_pkg::SUM_W'(p_ff[r][2])
                     + (lp2p_pkg::SUM_W'(t_ff[r]) <<< 16);
         end
         g3_ff <= g2_ff;
      end
   end

   // stage 4: sign and magnitude
   always_comb begin
      mag_u = s_ff[0][lp2p_pkg::SUM_W-1] ? -s_ff[0] : s_ff[0];
      mag_v = s_ff[1][lp2p_pkg::SUM_W-1] ? -s_ff[1] : s_ff[1];
      mag_w = s_ff[2][lp2p_pkg::SUM_W-1] ? -s_ff[2] : s_ff[2];
      item_in.ground = g3_ff;
      item_in.u_neg  = s_ff[0][lp2p_pkg::SUM_W-1];
      item_in.u_mag  = mag_u[63:0];
      item_in.v_neg  = s_ff[1][lp2p_pkg::SUM_W-1];
      item_in.v_mag  = mag_v[63:0];
      item_in.w_neg  = s_ff[2][lp2p_pkg::SUM_W-1];
      item_in.w_mag  = mag_w[63:0];
   end

   always_ff @(posedge clock) begin
      if (en[3]) item_ff <= item_in;
   end

   assign out_valid = v_ff[3];
   assign out_item  = item_ff;

endmodule

// ----- rtl/core/lp2p_div.sv -----
// Pipelined restoring divider: u/w and v/w, one quotient bit per stage.
`timescale 1ns / 1ps

module lp2p_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  lp2p_pkg::mac_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output lp2p_pkg::div_item_type out_item
);

   localparam int unsigned N = lp2p_pkg::QBITS + 1;

   logic [N-1:0] v_ff;
   logic [N:0]   en;
   lp2p_pkg::div_item_type item_ff [N];
   lp2p_pkg::div_item_type init_in;

   assign en[N]    = out_ready;
   assign in_ready = en[0];

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_en
         assign en[i] = !v_ff[i] || en[i+1];
      end
   endgenerate

   // stage 0: range check (quotient must fit QBITS) and threshold on w
   always_comb begin
      init_in.ground = in_item.ground;
      init_in.w_ok   = !in_item.w_neg && (in_item.w_mag > lp2p_pkg::W_MIN_RAW);
      init_in.w      = in_item.w_mag;
      init_in.u_neg  = in_item.u_neg;
      init_in.u_ovf  = lp2p_pkg::REM_W'(in_item.u_mag) >=
                       (lp2p_pkg::REM_W'(in_item.w_mag) << lp2p_pkg::QBITS);
      init_in.u_rem  = lp2p_pkg::REM_W'(in_item.u_mag);
      init_in.u_q    = '0;
      init_in.v_neg  = in_item.v_neg;
      init_in.v_ovf  = lp2p_pkg::REM_W'(in_item.v_mag) >=
                       (lp2p_pkg::REM_W'(in_item.w_mag) << lp2p_pkg::QBITS);
      init_in.v_rem  = lp2p_pkg::REM_W'(in_item.v_mag);
      init_in.v_q    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en[0]) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) item_ff[0] <= init_in;
   end

   generate
      for (i = 1; i < N; i++) begin : g_step
         localparam int K = N - 1 - i;
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[i] <= 1'b0;
            end else if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
         always_ff @(posedge clock) begin
            if (en[i]) item_ff[i] <= lp2p_pkg::div_step(item_ff[i-1], K);
         end
      end
   endgenerate

   assign out_valid = v_ff[N-1];
   assign out_item  = item_ff[N-1];

endmodule

// ----- rtl/core/lidar_point_to_pixel_projection.sv -----
// Top level: lidar point to camera pixel projection with ground flag.
`timescale 1ns / 1ps

// Projects one lidar point (x, y, z, 1; signed Q16.16) through a loaded 3x4
// Q16.16 matrix into homogeneous u, v, w, then returns round(u/w), round(v/w)
// (half away from zero) as pixel column and row. hit is set when w > 0.1 and
// the pixel lies inside the image; otherwise column, row and ground read 0.
// is_ground marks lower < z < upper from the ground band register. One word
// is taken every clock unless rsp stalls, through 4 multiply/sum stages, 18
// divider stages (range check plus one quotient bit per stage) and the output
// register. Each stage holds only while it is full and the next one is, so a
// stalled rsp side fills bubbles before req_tready drops. The user is to write
// registers through the csr port only while no word is in flight; the block
// does not enforce it. csr_ready is always high and an index above 7 is ignored.

module lidar_point_to_pixel_projection (
   input  logic        clock,
   input  logic        reset,
   // config write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [63:0] csr_data,
   // point input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // point_x [31:0], point_y [63:32], point_z [95:64]
   // pixel result
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pixel_col [15:0], pixel_row [31:16]
   output logic [1:0]  rsp_tuser    // hit [0], is_ground [1]
);

   lp2p_pkg::matrix_type matrix_ff;
   logic [31:0] image_size_ff;
   logic [63:0] ground_band_ff;

   logic                   mac_valid, mac_ready;
   lp2p_pkg::mac_item_type mac_item;
   logic                   div_valid, div_ready;
   lp2p_pkg::div_item_type div_item;

   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;

   logic [15:0] width, height;
   logic [lp2p_pkg::QBITS:0] u_idx, v_idx;
   logic u_round, v_round, u_fit, v_fit, hit;

   // ---- configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff      <= '0;
         image_size_ff  <= lp2p_pkg::IMAGE_SIZE_RESET;
         ground_band_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (lp2p_pkg::csr_index_type'(csr_index))
            lp2p_pkg::CSR_ROW0_A:      matrix_ff[0]   <= csr_data;
            lp2p_pkg::CSR_ROW0_B:      matrix_ff[1]   <= csr_data;
            lp2p_pkg::CSR_ROW1_A:      matrix_ff[2]   <= csr_data;
            lp2p_pkg::CSR_ROW1_B:      matrix_ff[3]   <= csr_data;
            lp2p_pkg::CSR_ROW2_A:      matrix_ff[4]   <= csr_data;
            lp2p_pkg::CSR_ROW2_B:      matrix_ff[5]   <= csr_data;
            lp2p_pkg::CSR_IMAGE_SIZE:  image_size_ff  <= csr_data[31:0];
            lp2p_pkg::CSR_GROUND_BAND: ground_band_ff <= csr_data;
            default: ;  // unmapped index: ignored
         endcase
      end
   end

   // ---- datapath
   lp2p_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .matrix      (matrix_ff),
      .ground_band (ground_band_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_x        ($signed(req_tdata[31:0])),
      .in_y        ($signed(req_tdata[63:32])),
      .in_z        ($signed(req_tdata[95:64])),
      .out_valid   (mac_valid),
      .out_ready   (mac_ready),
      .out_item    (mac_item)
   );

   lp2p_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mac_valid),
      .in_ready  (mac_ready),
      .in_item   (mac_item),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_item  (div_item)
   );

   // ---- rounding, bounds and output word
   assign width  = image_size_ff[15:0];
   assign height = image_size_ff[31:16];

   always_comb begin
      // remainder < w here, so its low 64 bits are all of it; round up when 2*rem >= w
      u_round = {div_item.u_rem[63:0], 1'b0} >= {1'b0, div_item.w};
      v_round = {div_item.v_rem[63:0], 1'b0} >= {1'b0, div_item.w};
      u_idx   = {1'b0, div_item.u_q} + {{lp2p_pkg::QBITS{1'b0}}, u_round};
      v_idx   = {1'b0, div_item.v_q} + {{lp2p_pkg::QBITS{1'b0}}, v_round};
      // a negative quotient that rounds to zero still counts as column/row 0
      u_fit   = !div_item.u_ovf && !(div_item.u_neg && (u_idx != '0)) &&
                (u_idx < (lp2p_pkg::QBITS+1)'(width));
      v_fit   = !div_item.v_ovf && !(div_item.v_neg && (v_idx != '0)) &&
                (v_idx < (lp2p_pkg::QBITS+1)'(height));
      hit     = div_item.w_ok && u_fit && v_fit;
      rsp_data_in = hit ? {v_idx[15:0], u_idx[15:0]} : 32'd0;
      rsp_user_in = {hit && div_item.ground, hit};
   end

   assign div_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_ready) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---- checks
   a_hit_in_image: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         (rsp_tdata[15:0] < image_size_ff[15:0]) && (rsp_tdata[31:16] < image_size_ff[31:16]))
      else $error("hit pixel outside image");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata == 32'd0) && !rsp_tuser[1])
      else $error("miss word carries nonzero fields");

   a_zero_w_miss: assert property (@(posedge clock) disable iff (reset)
      div_valid && div_item.w_ok |-> (div_item.w > lp2p_pkg::W_MIN_RAW))
      else $error("w threshold flag inconsistent");

endmodule

// ----- tb/lp2p_checker.sv -----
// Checker: watches the csr, point and pixel channels, predicts pixel words and compares them.
`timescale 1ns / 1ps

module lp2p_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          fail_count,
   output int          pending,
   output int          pixel_words,
   output int          hit_words,
   output int          ground_words
);

   typedef struct packed {
      logic        hit;
      logic [15:0] col;
      logic [15:0] row;
      logic        ground;
   } pixel_word_type;

   logic [63:0] proj_m [6];
   logic [31:0] img_dims;
   logic [63:0] band;
   pixel_word_type pixel_queue [$];

   // exact row sum as a signed 68-bit value
   function automatic logic signed [67:0] row_dot(int r, logic signed [31:0] px,
                                                  logic signed [31:0] py,
                                                  logic signed [31:0] pz);
      logic signed [67:0] acc;
      logic signed [31:0] k [4];
      logic [63:0]        ra, rb;
      begin
         ra = proj_m[r * 2];
         rb = proj_m[r * 2 + 1];
         k[0] = ra[31:0]; k[1] = ra[63:32]; k[2] = rb[31:0]; k[3] = rb[63:32];
         acc = 68'(k[0]) * 68'(px) + 68'(k[1]) * 68'(py) + 68'(k[2]) * 68'(pz)
             + (68'(k[3]) <<< 16);
         return acc;
      end
   endfunction

   // rounded index; ok clear when outside [0, lim-1]
   function automatic logic [64:0] round_index(logic signed [67:0] num,
                                               logic [67:0] w, logic [15:0] lim);
      logic [67:0] mag, q, rem;
      begin
         mag = num < 0 ? 68'(-num) : 68'(num);
         q = mag / w;
         rem = mag % w;
         if (rem >= w - rem) q = q + 1;
         if (num < 0 && q != 0) return '0;
         if (q >= 68'(lim)) return '0;
         return {1'b1, q[63:0]};
      end
   endfunction

   function automatic pixel_word_type project_point(logic [95:0] pt);
      logic signed [31:0] px, py, pz, lo, hi;
      logic signed [67:0] u, v, w;
      logic [64:0]        ci, ri;
      pixel_word_type     res;
      begin
         px = pt[31:0]; py = pt[63:32]; pz = pt[95:64];
         u = row_dot(0, px, py, pz);
         v = row_dot(1, px, py, pz);
         w = row_dot(2, px, py, pz);
         res = '0;
         if (w > $signed(68'(lp2p_pkg::W_MIN_RAW))) begin
            ci = round_index(u, 68'(w), img_dims[15:0]);
            ri = round_index(v, 68'(w), img_dims[31:16]);
            if (ci[64] && ri[64]) begin
               lo = band[31:0];
               hi = band[63:32];
               res.hit = 1'b1;
               res.col = ci[15:0];
               res.row = ri[15:0];
               res.ground = (pz > lo) && (pz < hi);
            end
         end
         return res;
      end
   endfunction

   always @(posedge clock) begin
      pixel_word_type exp_w, got;
      if (reset) begin
         for (int i = 0; i < 6; i++) proj_m[i] <= '0;
         img_dims <= lp2p_pkg::IMAGE_SIZE_RESET;
         band <= '0;
         pixel_queue.delete();
         fail_count <= 0;
         pending <= 0;
         pixel_words <= 0;
         hit_words <= 0;
         ground_words <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index <= lp2p_pkg::CSR_ROW2_B) proj_m[csr_index[2:0]] <= csr_data;
            else if (csr_index == lp2p_pkg::CSR_IMAGE_SIZE) img_dims <= csr_data[31:0];
            else if (csr_index == lp2p_pkg::CSR_GROUND_BAND) band <= csr_data;
         end
         if (req_tvalid && req_tready) pixel_queue.push_back(project_point(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[0], rsp_tdata[15:0], rsp_tdata[31:16], rsp_tuser[1]};
            pixel_words <= pixel_words + 1;
            hit_words <= hit_words + got.hit;
            ground_words <= ground_words + got.ground;
            if (pixel_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected pixel word %h", got);
               fail_count <= fail_count + 1;
            end else begin
               exp_w = pixel_queue.pop_front();
               if (exp_w != got) begin
                  if (fail_count < 10)
                     $display("mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                              exp_w.hit, exp_w.col, exp_w.row, exp_w.ground,
                              got.hit, got.col, got.row, got.ground);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= pixel_queue.size();
      end
   end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top: drives the projection block with config, points and back-pressure.
`timescale 1ns / 1ps

module tb_top;

   localparam int WATCHDOG = 20000;   // idle cycles before giving up
   localparam int DRAIN = 60;         // settling margin after the checker queue empties
   localparam logic [3:0] CSR_UNMAPPED = 4'd9;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // point_x [31:0], point_y [63:32], point_z [95:64]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // pixel_col [15:0], pixel_row [31:16]
   logic [1:0]  rsp_tuser;        // hit [0], is_ground [1]

   int fail_count, pending, pixel_words, hit_words, ground_words;
   int idle_cycles = 0;
   bit steady = 1'b0;   // when set, no random gaps on either side

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lidar_point_to_pixel_projection uut (.*);

   lp2p_checker chk (.*);

   // random stall on the pixel side
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= steady || ($urandom_range(99) >= 28);
   end

   // watchdog: cycles with no handshake anywhere
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("watchdog expired");
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic write_reg(logic [3:0] idx, logic [63:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // drive one point; random gap first unless steady; valid stays up after the handshake
   task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      while (!steady && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {pz, py, px};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_all();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   function automatic logic [31:0] q16(int whole);
      return 32'(whole) << 16;
   endfunction

   // coefficient pair packing: low word first column
   function automatic logic [63:0] pair(logic [31:0] lo, logic [31:0] hi);
      return {hi, lo};
   endfunction

   // realistic camera-like matrix: u = fx*x + cx*z, v = fy*y + cy*z, w = z
   task automatic load_camera(logic [31:0] fx, logic [31:0] fy,
                              logic [31:0] cx, logic [31:0] cy);
      write_reg(lp2p_pkg::CSR_ROW0_A, pair(fx, 32'd0));
      write_reg(lp2p_pkg::CSR_ROW0_B, pair(cx, 32'd0));
      write_reg(lp2p_pkg::CSR_ROW1_A, pair(32'd0, fy));
      write_reg(lp2p_pkg::CSR_ROW1_B, pair(cy, 32'd0));
      write_reg(lp2p_pkg::CSR_ROW2_A, 64'd0);
      write_reg(lp2p_pkg::CSR_ROW2_B, pair(q16(1), 32'd0));
   endtask

   // point with small coordinates in front of the camera
   task automatic send_scene_point();
      logic [31:0] px, py, pz;
      px = 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      py = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      pz = 32'($urandom_range(0, 30 << 16));
      send_point(px, py, pz);
   endtask

   function automatic logic [31:0] rand_edge32();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // matrix after reset: w is zero, nothing hits
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      drain_all();

      load_camera(q16(264), q16(264), q16(334), q16(183));
      // about -2.2 .. -1.9
      write_reg(lp2p_pkg::CSR_GROUND_BAND, pair(32'hFFFD_CCCD, 32'hFFFE_199A));
      // w just below and just above 0.1, off-image and behind camera
      send_point(32'd0, 32'd0, 32'd6553);
      send_point(32'd0, 32'd0, 32'd6554);
      send_point(32'd0, 32'd0, 32'd6555);
      send_point(q16(1), q16(1), q16(5));
      send_point(32'hFFFD_CCCD, q16(0), q16(10));
      send_point(q16(0), q16(0), 32'hFFFF_0000);       // behind the camera
      send_point(q16(-20), q16(0), q16(5));             // negative column
      send_point(32'hFFFF_F000, 32'd0, q16(1));          // tiny negative x
      send_point(32'h0000_8000, 32'h0000_8000, q16(264));// exact half
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      drain_all();

      // z inside and on the edges of the band; w from x plus one
      write_reg(lp2p_pkg::CSR_ROW2_A, pair(q16(1), 32'd0));
      write_reg(lp2p_pkg::CSR_ROW2_B, pair(32'd0, q16(1)));
      send_point(q16(3), q16(0), 32'hFFFE_0000);
      send_point(q16(3), q16(0), 32'hFFFD_CCCD);
      send_point(q16(3), q16(0), 32'hFFFE_199A);
      drain_all();

      // zero width, then one-pixel image
      write_reg(lp2p_pkg::CSR_IMAGE_SIZE, {16'd376, 16'd0});
      send_point(q16(0), q16(0), q16(1));
      drain_all();
      write_reg(lp2p_pkg::CSR_IMAGE_SIZE, {16'd1, 16'd1});
      send_point(q16(0), q16(0), q16(1));
      drain_all();
      write_reg(lp2p_pkg::CSR_IMAGE_SIZE, 32'hFFFF_FFFF);
      write_reg(lp2p_pkg::CSR_GROUND_BAND, pair(32'h8000_0000, 32'h7FFF_FFFF));
      write_reg(CSR_UNMAPPED, 64'hDEAD_BEEF);   // beyond the map, ignored
      send_point(q16(1), q16(2), q16(3));
      drain_all();

      // random phases: mostly camera-like matrices with scene points
      for (int ph = 0; ph < 8; ph++) begin
         if (ph % 3 == 2) begin
            for (int r = 0; r < 6; r++)
               write_reg(4'(r), {rand_edge32(), rand_edge32()});
         end else begin
            load_camera(32'($urandom_range(50 << 16, 700 << 16)),
                        32'($urandom_range(50 << 16, 700 << 16)),
                        32'($urandom_range(0, 700 << 16)),
                        32'($urandom_range(0, 400 << 16)));
         end
         write_reg(lp2p_pkg::CSR_IMAGE_SIZE,
                   (ph == 0) ? lp2p_pkg::IMAGE_SIZE_RESET
                             : {16'($urandom_range(1, 800)), 16'($urandom_range(1, 800))});
         write_reg(lp2p_pkg::CSR_GROUND_BAND,
                   pair(32'($signed($urandom_range(0, 40 << 16)) - (20 << 16)),
                        32'($urandom_range(0, 20 << 16))));
         steady = (ph == 4);
         for (int i = 0; i < 50; i++) begin
            if (ph % 3 == 2 || $urandom_range(9) == 0)
               send_point(rand_edge32(), rand_edge32(), rand_edge32());
            else send_scene_point();
         end
         steady = 1'b0;
         drain_all();
      end

      $display("covered reset matrix, w threshold, rounding halves, image edges, ground band limits");
      $display("%0d pixel words, %0d hits, %0d ground", pixel_words, hit_words, ground_words);
      if (fail_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
